### rtl/sha_pkg.sv
// Shared types and codes for the SHA-256 stream hasher.
package sha_pkg;

	// Request action codes
	localparam logic [1:0] ACT_ABSORB     = 2'd0;
	localparam logic [1:0] ACT_ABSORB_FIN = 2'd1;
	localparam logic [1:0] ACT_FINISH     = 2'd2;

	// Byte source for the block shift path
	localparam logic [1:0] SEL_DATA  = 2'd0;
	localparam logic [1:0] SEL_PAD80 = 2'd1;
	localparam logic [1:0] SEL_ZERO  = 2'd2;
	localparam logic [1:0] SEL_LEN   = 2'd3;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] data_byte;
	} sha_in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} sha_out_t;

	// Controller to datapath commands
	typedef struct packed {
		logic       shift;
		logic [1:0] sel;
		logic       ld_vars;
		logic       round;
		logic       fold;
		logic       out_ld;
		logic       hash_init;
		logic [5:0] rnd;
		logic [2:0] widx;
	} sha_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [5:0] cnt;
	} sha_sts_t;

endpackage

### rtl/sha_dp.sv
// SHA-256 datapath: block/schedule window, round logic, hash words, output register.
module sha_dp import sha_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  sha_cmd_t cmd,
	input  logic [7:0] data_byte,
	output sha_sts_t sts,
	output sha_out_t out_data
);

	localparam logic [63:0][31:0] K = {
		32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
		32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
		32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
		32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
		32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
		32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
		32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
		32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
		32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
		32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
		32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
		32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
		32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
		32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
		32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
		32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
	};

	localparam logic [7:0][31:0] IV = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
	endfunction

	// blk_q holds the block bytes in arrival order; during rounds it is the
	// 16-word schedule window, word t at the top.
	logic [511:0]       blk_q;
	logic [5:0]         cnt_q;
	logic [63:0]        bits_q;
	logic [7:0][31:0]   hash_q;
	logic [7:0][31:0]   v_q;
	sha_out_t           out_q;

	logic [7:0]  byte_in;
	logic [31:0] w0, w1, w9, w14, w_new;
	logic [31:0] t1, t2;

	always_comb begin
		unique case (cmd.sel)
			SEL_DATA:  byte_in = data_byte;
			SEL_PAD80: byte_in = 8'h80;
			SEL_ZERO:  byte_in = 8'h00;
			SEL_LEN:   byte_in = bits_q[63:56];
			default:   byte_in = 8'h00;
		endcase
	end

	assign w0    = blk_q[511:480];
	assign w1    = blk_q[479:448];
	assign w9    = blk_q[223:192];
	assign w14   = blk_q[63:32];
	assign w_new = ssig1(w14) + w9 + ssig0(w1) + w0;

	assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ K[cmd.rnd] + w0;
	assign t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	// State with a defined reset value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			bits_q <= '0;
			hash_q <= IV;
		end else begin
			if (cmd.shift) begin
				cnt_q <= cnt_q + 6'd1;
				if (cmd.sel == SEL_DATA)
					bits_q <= bits_q + 64'd8;
				else if (cmd.sel == SEL_LEN)
					bits_q <= {bits_q[55:0], 8'h00};
			end
			if (cmd.fold) begin
				for (int i = 0; i < 8; i++)
					hash_q[i] <= hash_q[i] + v_q[i];
			end
			if (cmd.hash_init)
				hash_q <= IV;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.shift)
			blk_q <= {blk_q[503:0], byte_in};
		else if (cmd.round)
			blk_q <= {blk_q[479:0], w_new};
		if (cmd.ld_vars)
			v_q <= hash_q;
		else if (cmd.round)
			v_q <= {v_q[6], v_q[5], v_q[4], v_q[3] + t1, v_q[2], v_q[1], v_q[0], t1 + t2};
		if (cmd.out_ld) begin
			out_q.digest_word <= hash_q[cmd.widx];
			out_q.word_index  <= cmd.widx;
			out_q.last_word   <= (cmd.widx == 3'd7);
		end
	end

	assign sts.cnt  = cnt_q;
	assign out_data = out_q;

endmodule

### rtl/sha_ctrl.sv
// SHA-256 controller: request intake, padding sequence, round count, digest readout.
module sha_ctrl import sha_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] action,
	output logic       out_valid,
	input  logic       out_ready,
	input  sha_sts_t   sts,
	output sha_cmd_t   cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_PAD80  = 3'd1;
	localparam logic [2:0] ST_PADZ   = 3'd2;
	localparam logic [2:0] ST_PADLEN = 3'd3;
	localparam logic [2:0] ST_LOAD   = 3'd4;
	localparam logic [2:0] ST_COMP   = 3'd5;
	localparam logic [2:0] ST_FOLD   = 3'd6;
	localparam logic [2:0] ST_OUT    = 3'd7;

	logic [2:0] st_q, st_d;
	logic [2:0] ret_q, ret_d;
	logic [5:0] rnd_q, rnd_d;
	logic [2:0] widx_q, widx_d;
	logic       ov_q, ov_d;

	always_comb begin
		st_d     = st_q;
		ret_d    = ret_q;
		rnd_d    = rnd_q;
		widx_d   = widx_q;
		ov_d     = ov_q && !out_ready;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.rnd  = rnd_q;
		cmd.widx = widx_q;
		unique case (st_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (action)
						ACT_ABSORB, ACT_ABSORB_FIN: begin
							cmd.shift = 1'b1;
							cmd.sel   = SEL_DATA;
							if (sts.cnt == 6'd63) begin
								st_d  = ST_LOAD;
								ret_d = (action == ACT_ABSORB_FIN) ? ST_PAD80 : ST_IDLE;
							end else if (action == ACT_ABSORB_FIN) begin
								st_d = ST_PAD80;
							end
						end
						ACT_FINISH: st_d = ST_PAD80;
						default: ;
					endcase
				end
			end
			ST_PAD80, ST_PADZ: begin
				cmd.shift = 1'b1;
				cmd.sel   = (st_q == ST_PAD80) ? SEL_PAD80 : SEL_ZERO;
				if (sts.cnt == 6'd55) begin
					st_d = ST_PADLEN;
				end else if (sts.cnt == 6'd63) begin
					st_d  = ST_LOAD;
					ret_d = ST_PADZ;
				end else begin
					st_d = ST_PADZ;
				end
			end
			ST_PADLEN: begin
				cmd.shift = 1'b1;
				cmd.sel   = SEL_LEN;
				if (sts.cnt == 6'd63) begin
					st_d  = ST_LOAD;
					ret_d = ST_OUT;
				end
			end
			ST_LOAD: begin
				cmd.ld_vars = 1'b1;
				rnd_d       = '0;
				st_d        = ST_COMP;
			end
			ST_COMP: begin
				cmd.round = 1'b1;
				rnd_d     = rnd_q + 6'd1;
				if (rnd_q == 6'd63)
					st_d = ST_FOLD;
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				st_d     = ret_q;
			end
			ST_OUT: begin
				if (!ov_q || out_ready) begin
					cmd.out_ld = 1'b1;
					ov_d       = 1'b1;
					widx_d     = widx_q + 3'd1;
					if (widx_q == 3'd7) begin
						cmd.hash_init = 1'b1;
						st_d          = ST_IDLE;
					end
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			ret_q  <= ST_IDLE;
			rnd_q  <= '0;
			widx_q <= '0;
			ov_q   <= 1'b0;
		end else begin
			st_q   <= st_d;
			ret_q  <= ret_d;
			rnd_q  <= rnd_d;
			widx_q <= widx_d;
			ov_q   <= ov_d;
		end
	end

	assign out_valid = ov_q;

endmodule

### rtl/sha256_stream_hasher.sv
// SHA-256 stream hasher top level: controller plus datapath.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one request per accepted
//   cycle: absorb a byte, absorb a byte then finish, or finish alone. An
//   unused action code is accepted and dropped.
//   Output channel (out_valid/out_ready/out_data) returns the eight digest
//   words of a finished message, word 0 first, last_word set on word 7.
// Timing:
//   Each absorb request shifts its byte in as it is accepted. The request that
//   fills a 64-byte block also starts a compression (load, 64 rounds through a
//   single round unit, fold into the hash words), during which in_ready is low.
//   A finish feeds the padding bytes through the same byte shift path, one
//   per cycle, then the 8 length bytes, then compresses; two compressions run
//   when the padding spills into a second block or the finishing byte
//   completes one. Readout then gives one word per cycle while out_ready is
//   held high.
// Reset: arst_n clears the controller, the byte and bit counts, and loads
//   the standard initial hash words; no clearing pass is needed.
// Stall: the digest sits in an output register; while the receiver holds
//   out_ready low readout pauses, but absorb requests for the next message
//   are still taken once the block has returned to idle.
module sha256_stream_hasher import sha_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  sha_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output sha_out_t out_data
);

	sha_cmd_t cmd;
	sha_sts_t sts;

	// Sequencing: intake, padding, round counting, readout handshake.
	sha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (in_data.action),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Block window, message schedule, round unit, hash words, output register.
	sha_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.data_byte (in_data.data_byte),
		.sts       (sts),
		.out_data  (out_data)
	);

endmodule

### rtl/sha_chk.sv
// Port-level checker for the SHA-256 stream hasher, with its bind.
module sha_chk import sha_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input sha_in_t  in_data,
	input logic     out_valid,
	input logic     out_ready,
	input sha_out_t out_data
);

	// A stalled digest word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("digest word changed while stalled");

	// Last flag marks word 7 and only word 7.
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.last_word == (out_data.word_index == 3'd7)))
		else $error("last_word does not match word_index");

	// Digest words come out in order.
	a_word_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last_word |=>
		!out_valid || (out_data.word_index == 3'($past(out_data.word_index) + 3'd1)))
		else $error("digest word out of order");

	// A finishing request starts padding or a compression, so intake closes next cycle.
	a_finish_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready &&
		(in_data.action == ACT_FINISH || in_data.action == ACT_ABSORB_FIN)
		|=> !in_ready)
		else $error("intake open right after finish request");

endmodule

bind sha256_stream_hasher sha_chk u_chk (.*);

### bench/tb_sha256_stream_hasher.sv
`timescale 1ns / 1ps
// Self-checking bench for the SHA-256 stream hasher, with its own digest predictor.
module tb_sha256_stream_hasher;
	import sha_pkg::*;

	// The package names three actions; the fourth code is accepted and dropped.
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	localparam int HOLD_OFF_CYCLES = 1500;	// long receiver stall to back up the input
	localparam int HOLD_OFF_AFTER  = 24;	// start it once three digests have drained
	localparam int DRAIN_CYCLES    = 300;	// quiet tail after the last expected digest word
	localparam int RANDOM_ITEMS    = 100;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] HASH_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     in_valid  = 1'b0;
	logic     in_ready;
	sha_in_t  in_data   = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	sha_out_t out_data;

	sha256_stream_hasher DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ------------------------------------------------------------------
	// Digest predictor: running hash, the partial block, its fill count
	// (6 bits, wraps to 0 exactly when the block is full) and the 64-bit
	// message length in bits.
	// ------------------------------------------------------------------
	logic [31:0] run_hash [8] = HASH_IV;
	logic [7:0]  blk_bytes [64];
	logic [5:0]  blk_fill = '0;
	logic [63:0] msg_bits = '0;

	sha_in_t  requests_to_send [$];	// request stream, drained by the driver
	sha_out_t digest_words_due [$];	// predicted digest words, oldest first

	int mismatches = 0;
	int words_seen = 0;

	function automatic logic [31:0] rotr(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// 64 rounds over blk_bytes with a rolling 16-word schedule, then fold.
	function automatic void compress_block();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, e, f, g, h;
		logic [31:0] s0, s1, t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
		a = run_hash[0]; b = run_hash[1]; c = run_hash[2]; d = run_hash[3];
		e = run_hash[4]; f = run_hash[5]; g = run_hash[6]; h = run_hash[7];
		for (int r = 0; r < 64; r++) begin
			if (r >= 16) begin
				s0 = rotr(w[(r-15)&15], 7) ^ rotr(w[(r-15)&15], 18) ^ (w[(r-15)&15] >> 3);
				s1 = rotr(w[(r-2)&15], 17) ^ rotr(w[(r-2)&15], 19) ^ (w[(r-2)&15] >> 10);
				w[r&15] = s1 + w[(r-7)&15] + s0 + w[r&15];
			end
			t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
				+ ROUND_K[r] + w[r&15];
			t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		run_hash[0] += a; run_hash[1] += b; run_hash[2] += c; run_hash[3] += d;
		run_hash[4] += e; run_hash[5] += f; run_hash[6] += g; run_hash[7] += h;
	endfunction

	function automatic void absorb_byte(logic [7:0] b);
		blk_bytes[blk_fill] = b;
		blk_fill += 6'd1;
		msg_bits += 64'd8;
		if (blk_fill == 6'd0)
			compress_block();
	endfunction

	// Pad, append the length, compress, queue eight words, restart the message.
	function automatic void finish_digest();
		int pos;
		sha_out_t word;
		pos = blk_fill;
		blk_bytes[pos] = 8'h80;
		pos++;
		if (pos > 56) begin
			// no room for the length field: close this block, pad a fresh one
			while (pos < 64) begin
				blk_bytes[pos] = 8'h00;
				pos++;
			end
			compress_block();
			pos = 0;
		end
		while (pos < 56) begin
			blk_bytes[pos] = 8'h00;
			pos++;
		end
		for (int i = 0; i < 8; i++)
			blk_bytes[56+i] = msg_bits[63-8*i -: 8];
		compress_block();
		for (int i = 0; i < 8; i++) begin
			word.digest_word = run_hash[i];
			word.word_index  = 3'(i);
			word.last_word   = (i == 7);
			digest_words_due.push_back(word);
		end
		run_hash = HASH_IV;
		blk_fill = '0;
		msg_bits = '0;
	endfunction

	function automatic void predict_request(sha_in_t req);
		case (req.action)
			ACT_ABSORB: begin
				absorb_byte(req.data_byte);
			end
			ACT_ABSORB_FIN: begin
				absorb_byte(req.data_byte);
				finish_digest();
			end
			ACT_FINISH: begin
				finish_digest();
			end
			default: begin
				// unused code: dropped without touching the hash state
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic queue_request(logic [1:0] act, logic [7:0] b);
		sha_in_t req;
		req.action    = act;
		req.data_byte = b;
		requests_to_send.push_back(req);
	endtask

	// One well-formed message of len bytes with random content. It ends either
	// with the last byte carrying the finish or with a separate finish request.
	// A few dropped requests are sprinkled in as noise.
	task automatic queue_message(int len);
		bit fin_on_byte;
		fin_on_byte = (len > 0) && ($urandom_range(1) == 1);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(15) == 0)
				queue_request(ACT_UNUSED, 8'($urandom_range(255)));
			if (fin_on_byte && i == len - 1)
				queue_request(ACT_ABSORB_FIN, 8'($urandom_range(255)));
			else
				queue_request(ACT_ABSORB, 8'($urandom_range(255)));
		end
		if (!fin_on_byte)
			queue_request(ACT_FINISH, 8'($urandom_range(255)));
	endtask

	// ------------------------------------------------------------------
	// Run control: reset once, build the request stream, wait for drain.
	// ------------------------------------------------------------------
	initial begin
		int msg_len;

		// Directed part.
		// Empty message; the byte on a bare finish is don't-care.
		queue_request(ACT_FINISH, 8'hff);
		// "abc", the classic short vector, finished on its last byte.
		queue_request(ACT_ABSORB, 8'h61);
		queue_request(ACT_ABSORB, 8'h62);
		queue_request(ACT_ABSORB_FIN, 8'h63);
		// Byte extremes with a dropped request in the middle of a message.
		queue_request(ACT_ABSORB, 8'h00);
		queue_request(ACT_ABSORB, 8'hff);
		queue_request(ACT_UNUSED, 8'h3c);
		queue_request(ACT_FINISH, 8'h00);
		// One-byte message equal to the pad marker.
		queue_request(ACT_ABSORB_FIN, 8'h80);
		// Dropped request between messages, then another empty message.
		queue_request(ACT_UNUSED, 8'hff);
		queue_request(ACT_FINISH, 8'h55);

		// Random part: one message long enough to force the padding into a
		// second block (or to land exactly on a block), then mostly short
		// messages with the odd long one.
		queue_message($urandom_range(56, 64));
		while (requests_to_send.size() < RANDOM_ITEMS) begin
			if ($urandom_range(9) == 0)
				msg_len = $urandom_range(40, 70);
			else
				msg_len = $urandom_range(0, 12);
			queue_message(msg_len);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// All requests taken, then all predicted words returned.
		@(posedge clk);
		while (requests_to_send.size() > 0 || in_valid)
			@(posedge clk);
		while (digest_words_due.size() > 0)
			@(posedge clk);
		// Quiet tail: catches stray words after the last expected one.
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// ------------------------------------------------------------------
	// Driver: bursts of requests with random gaps. A request is predicted
	// at the edge where it is accepted; valid is held with the payload
	// until then.
	// ------------------------------------------------------------------
	int      burst_left = 1;
	int      gap_left   = 0;
	logic    offer_next;
	sha_in_t next_req;

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			offer_next = in_valid;
			if (in_valid && in_ready) begin
				predict_request(in_data);
				offer_next = 1'b0;
			end
			if (!offer_next) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (requests_to_send.size() > 0) begin
					next_req = requests_to_send.pop_front();
					in_data <= next_req;
					offer_next = 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						// occasionally a long unbroken run, otherwise short bursts
						burst_left = ($urandom_range(4) == 0) ? $urandom_range(30, 80)
							: $urandom_range(1, 12);
						gap_left = $urandom_range(1, 15);
					end
				end
			end
			in_valid <= offer_next;
		end
	end

	// ------------------------------------------------------------------
	// Receiver: stretches of always-ready, coin-flip and mostly-stalled
	// readout, plus one long hold-off once a few digests have drained, so
	// the output register stays full and a later finish backs up the input.
	// ------------------------------------------------------------------
	int   rx_mode      = 0;
	int   rx_left      = 0;
	int   hold_left    = 0;
	bit   hold_done    = 1'b0;
	logic rdy_next;

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (hold_left > 0) begin
				hold_left--;
				rdy_next = 1'b0;
			end else if (!hold_done && words_seen >= HOLD_OFF_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_OFF_CYCLES - 1;
				rdy_next = 1'b0;
			end else begin
				if (rx_left == 0) begin
					rx_mode = $urandom_range(2);
					rx_left = $urandom_range(5, 60);
				end
				rx_left--;
				case (rx_mode)
					0:       rdy_next = 1'b1;
					1:       rdy_next = ($urandom_range(1) == 1);
					default: rdy_next = ($urandom_range(3) == 0);
				endcase
			end
			out_ready <= rdy_next;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: each accepted word against the oldest prediction.
	// ------------------------------------------------------------------
	sha_out_t want;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			words_seen <= words_seen + 1;
			if (digest_words_due.size() == 0) begin
				if (mismatches < 10)
					$display("[%0t] digest word with nothing pending: %h idx %0d last %b",
						$realtime, out_data.digest_word, out_data.word_index,
						out_data.last_word);
				mismatches++;
			end else begin
				want = digest_words_due.pop_front();
				if (out_data.digest_word !== want.digest_word ||
				    out_data.word_index  !== want.word_index  ||
				    out_data.last_word   !== want.last_word) begin
					if (mismatches < 10)
						$display("[%0t] digest word wrong: exp %h idx %0d last %b, got %h idx %0d last %b",
							$realtime, want.digest_word, want.word_index, want.last_word,
							out_data.digest_word, out_data.word_index, out_data.last_word);
					mismatches++;
				end
			end
		end
	end

endmodule
